// ----- rtl/bife_pkg.sv -----
// Shared constants, types and state codes of the biphase IR frame encoder.
`timescale 1ns / 1ps

package bife_pkg;

  localparam int COMMAND_BITS_DEF = 7;
  localparam int HALF_BIT_W       = 16;
  localparam int CODE_W           = 5;
  localparam int DUR_W            = 17;
  localparam int TOTAL_W          = 22;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [HALF_BIT_W-1:0] HALF_BIT_RESET = 16'd315;

  localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT_TIME  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_CODE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUBDEVICE_CODE = 2'd2;

  typedef struct packed {
    logic [HALF_BIT_W-1:0] half_bit_time;
    logic [CODE_W-1:0]     device_code;
    logic [CODE_W-1:0]     subdevice_code;
  } bife_cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_START,
    B_BIT,
    B_SECOND,
    B_FLUSH
  } bife_state_t;

  // start bit, device bits, subdevice bits, command bits
  function automatic int frame_bits(int command_bits);
    return 1 + 2 * CODE_W + command_bits;
  endfunction

endpackage

// ----- rtl/bife_if.sv -----
// Command and result channel interfaces of the biphase IR frame encoder.
`timescale 1ns / 1ps

interface bife_cmd_if #(
  parameter int COMMAND_BITS = bife_pkg::COMMAND_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [COMMAND_BITS-1:0] command_code;

  modport source (output valid, output command_code, input ready);
  modport sink   (input valid, input command_code, output ready);
endinterface

interface bife_res_if;
  logic                          valid;
  logic                          ready;
  logic [bife_pkg::DUR_W-1:0]    duration_us;
  logic                          is_pulse;
  logic [bife_pkg::TOTAL_W-1:0]  frame_total_us;
  logic                          last;

  modport source (output valid, output duration_us, output is_pulse,
                  output frame_total_us, output last, input ready);
  modport sink   (input valid, input duration_us, input is_pulse,
                  input frame_total_us, input last, output ready);
endinterface

// ----- rtl/bife_queue.sv -----
// Small flip-flop queue of frame words between front and back.
`timescale 1ns / 1ps

module bife_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = bife_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  // DEPTH is a power of two so the pointers wrap on their own
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W + 1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/bife_front.sv -----
// Front end: accept command beats and queue the assembled frame bit word.
`timescale 1ns / 1ps

module bife_front #(
  parameter int COMMAND_BITS = bife_pkg::COMMAND_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bife_pkg::bife_cfg_t cfg,
  bife_cmd_if.sink            cmd,
  output logic                q_valid,
  output logic [bife_pkg::frame_bits(COMMAND_BITS)-1:0] q_word,
  input  logic                q_pop
);
  import bife_pkg::*;

  localparam int FRAME_BITS = frame_bits(COMMAND_BITS);

  logic [FRAME_BITS-1:0] word;
  logic                  full;
  logic                  empty;

  // start bit on top, then device, subdevice and command, all MSB first
  assign word      = {1'b1, cfg.device_code, cfg.subdevice_code, cmd.command_code};
  assign cmd.ready = !full;
  assign q_valid   = !empty;

  bife_queue #(
    .WIDTH (FRAME_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd.valid),
    .push_data (word),
    .full      (full),
    .pop       (q_pop),
    .pop_data  (q_word),
    .empty     (empty)
  );

endmodule

// ----- rtl/bife_back.sv -----
// Back end: walk the frame bits and emit merged biphase durations.
`timescale 1ns / 1ps

module bife_back #(
  parameter int COMMAND_BITS = bife_pkg::COMMAND_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bife_pkg::bife_cfg_t cfg,
  input  logic                q_valid,
  input  logic [bife_pkg::frame_bits(COMMAND_BITS)-1:0] q_word,
  output logic                q_pop,
  bife_res_if.source          res
);
  import bife_pkg::*;

  localparam int FRAME_BITS = frame_bits(COMMAND_BITS);
  localparam int CNT_W      = $clog2(FRAME_BITS);

  bife_state_t           state, state_next;
  logic [FRAME_BITS-1:0] shreg, shreg_next;
  logic [CNT_W-1:0]      remain, remain_next;
  logic                  prev_bit, prev_bit_next;
  logic [TOTAL_W-1:0]    total, total_next;

  logic                  out_valid, out_valid_next;
  logic [DUR_W-1:0]      dur, dur_next;
  logic                  pulse, pulse_next;
  logic [TOTAL_W-1:0]    tot_out, tot_out_next;
  logic                  last, last_next;

  logic                  emit_ok;
  logic                  emit;
  logic [DUR_W-1:0]      e_dur;
  logic                  e_pulse;
  logic                  e_last;
  logic                  consume;
  logic                  cur;
  logic [DUR_W-1:0]      u_one;
  logic [DUR_W-1:0]      u_two;

  assign emit_ok = !out_valid || res.ready;
  assign cur     = shreg[FRAME_BITS-1];
  assign u_one   = {1'b0, cfg.half_bit_time};
  assign u_two   = {cfg.half_bit_time, 1'b0};

  assign res.valid          = out_valid;
  assign res.duration_us    = dur;
  assign res.is_pulse       = pulse;
  assign res.frame_total_us = tot_out;
  assign res.last           = last;

  always_comb begin
    state_next     = state;
    shreg_next     = shreg;
    remain_next    = remain;
    prev_bit_next  = prev_bit;
    total_next     = total;
    q_pop          = 1'b0;
    out_valid_next = out_valid && !res.ready;
    dur_next       = dur;
    pulse_next     = pulse;
    tot_out_next   = tot_out;
    last_next      = last;
    emit           = 1'b0;
    e_dur          = u_one;
    e_pulse        = 1'b0;
    e_last         = 1'b0;
    consume        = 1'b0;

    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          shreg_next = q_word;
          total_next = '0;
          state_next = B_START;
        end
      end
      B_START: begin
        // nothing held yet: the start bit's first half goes out alone
        if (emit_ok) begin
          emit          = 1'b1;
          e_pulse       = 1'b1;
          prev_bit_next = 1'b1;
          shreg_next    = shreg << 1;
          remain_next   = CNT_W'(FRAME_BITS - 1);
          state_next    = B_BIT;
        end
      end
      B_BIT: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (cur != prev_bit) begin
            // held half has the level of this first half: merge
            e_dur   = u_two;
            e_pulse = cur;
            consume = 1'b1;
          end else begin
            // send the held half, then this first half from B_SECOND
            e_pulse    = !cur;
            state_next = B_SECOND;
          end
        end
      end
      B_SECOND: begin
        if (emit_ok) begin
          emit    = 1'b1;
          e_pulse = cur;
          consume = 1'b1;
        end
      end
      B_FLUSH: begin
        if (emit_ok) begin
          emit       = 1'b1;
          e_pulse    = !prev_bit;
          e_last     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase

    if (consume) begin
      shreg_next    = shreg << 1;
      prev_bit_next = cur;
      remain_next   = remain - 1'b1;
      state_next    = (remain == CNT_W'(1)) ? B_FLUSH : B_BIT;
    end

    if (emit) begin
      total_next     = total + TOTAL_W'(e_dur);
      out_valid_next = 1'b1;
      dur_next       = e_dur;
      pulse_next     = e_pulse;
      last_next      = e_last;
      tot_out_next   = e_last ? total_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg    <= shreg_next;
    remain   <= remain_next;
    prev_bit <= prev_bit_next;
    total    <= total_next;
    dur      <= dur_next;
    pulse    <= pulse_next;
    tot_out  <= tot_out_next;
    last     <= last_next;
  end

endmodule

// ----- rtl/biphase_ir_frame_encoder.sv -----
// Top level of the biphase IR frame encoder: registers, front end and back end.
//
//   channel  dir  beat payload
//   -------  ---  -------------------------------------------------------
//   cmd      in   command_code[COMMAND_BITS-1:0]
//   res      out  duration_us[16:0], is_pulse, frame_total_us[21:0], last
//   cfg_*    in   cfg_wr_en, cfg_index[1:0], cfg_wr_data[15:0], no read-back
//
// A frame of R result beats (R from one more than the frame bit count up to
// twice that count, 19 to 36 at seven command bits) is handled in the back
// end by first popping the queued frame word, then emitting one merged
// duration per cycle from its bit sequencer while res is not stalled.
// The front end holds up to two queued frames, so cmd stays ready while
// the back end works, and stalls only when that queue is full.
// A stalled res beat holds in the output register; the sequencer waits.
// Reset (rst, synchronous) empties the queue, idles the sequencer and
// loads the registers with their defaults (half bit 315 us, codes 0).
`timescale 1ns / 1ps

module biphase_ir_frame_encoder #(
  parameter int COMMAND_BITS = bife_pkg::COMMAND_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [bife_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bife_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  bife_cmd_if.sink                         cmd,
  bife_res_if.source                       res
);
  import bife_pkg::*;

  localparam int FRAME_BITS = frame_bits(COMMAND_BITS);

  bife_cfg_t             cfg;
  logic                  q_valid;
  logic [FRAME_BITS-1:0] q_word;
  logic                  q_pop;

  // Register file: writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit_time  <= HALF_BIT_RESET;
      cfg.device_code    <= '0;
      cfg.subdevice_code <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HALF_BIT_TIME:  cfg.half_bit_time  <= cfg_wr_data[HALF_BIT_W-1:0];
        REG_DEVICE_CODE:    cfg.device_code    <= cfg_wr_data[CODE_W-1:0];
        REG_SUBDEVICE_CODE: cfg.subdevice_code <= cfg_wr_data[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: capture the command with the address codes into a frame word.
  bife_front #(
    .COMMAND_BITS (COMMAND_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  // Back: turn each frame word into alternating pulse and space beats.
  bife_back #(
    .COMMAND_BITS (COMMAND_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

// ----- rtl/bife_checker.sv -----
// Port-level checks on the result channel, bound to the encoder top level.
`timescale 1ns / 1ps

module bife_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [bife_pkg::DUR_W-1:0]   duration_us,
  input logic                         is_pulse,
  input logic [bife_pkg::TOTAL_W-1:0] frame_total_us,
  input logic                         last
);

  logic have_prev;
  logic prev_pulse;
  logic prev_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      prev_pulse <= 1'b0;
      prev_last  <= 1'b0;
    end else if (res_valid && res_ready) begin
      have_prev  <= 1'b1;
      prev_pulse <= is_pulse;
      prev_last  <= last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(duration_us) &&
      $stable(is_pulse) && $stable(frame_total_us) && $stable(last))
    else $error("result beat changed while stalled");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> frame_total_us == '0)
    else $error("frame total shown before the last beat");

  a_alternate: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && have_prev && !prev_last |-> is_pulse != prev_pulse)
    else $error("pulse and space do not alternate within a frame");

  a_frame_opens: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && (!have_prev || prev_last) |-> is_pulse)
    else $error("frame does not open with a pulse");

endmodule

bind biphase_ir_frame_encoder bife_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .duration_us    (res.duration_us),
  .is_pulse       (res.is_pulse),
  .frame_total_us (res.frame_total_us),
  .last           (res.last)
);

// ----- test/tb_biphase_ir_frame_encoder.sv -----
// Self-checking testbench of the biphase IR frame encoder: predicted frames versus result beats.
`timescale 1ns / 1ps

module tb_biphase_ir_frame_encoder;
  import bife_pkg::*;

  localparam int CMD_BITS      = COMMAND_BITS_DEF;
  // start bit, device bits, subdevice bits, command bits
  localparam int FRAME_BITS    = 1 + 2 * CODE_W + CMD_BITS;
  localparam int MAX_GAP       = 17;
  // margin for the back end to settle after a frame of up to 36 beats
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASE_ITEMS   = 24;
  localparam int RANDOM_PHASES = 8;
  localparam int MAX_REPORTS   = 30;

  // One carrier on or off interval as the result channel carries it.
  typedef struct packed {
    logic [DUR_W-1:0]   duration_us;
    logic               is_pulse;
    logic [TOTAL_W-1:0] frame_total_us;
    logic               last;
  } ir_interval_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  bife_cmd_if #(.COMMAND_BITS(CMD_BITS)) cmd_ch ();
  bife_res_if                            res_ch ();

  biphase_ir_frame_encoder #(
    .COMMAND_BITS(CMD_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .res         (res_ch)
  );

  // Our own copy of the register file, updated as each write lands.
  logic [HALF_BIT_W-1:0] half_bit_us;
  logic [CODE_W-1:0]     device_bits;
  logic [CODE_W-1:0]     subdevice_bits;

  // Intervals still owed by the block, oldest first.
  ir_interval_t interval_q[$];

  int  mismatch_count;
  int  frames_sent;
  int  frames_done;
  int  intervals_done;
  int  settings_used;
  // when set, the matching side never idles between beats
  bit  tx_steady;
  bit  rx_steady;

  always #10 clk = ~clk;

  // Build every interval of one frame and append them to interval_q.
  function automatic void encode_frame(input logic [CMD_BITS-1:0] code);
    logic [FRAME_BITS-1:0] bits;
    logic [HALF_BIT_W-1:0] held_time;
    logic                  held_pulse;
    logic                  held_space;
    logic                  one;
    logic                  same_level;
    logic                  other_level;
    logic [DUR_W-1:0]      dur;
    logic [TOTAL_W-1:0]    total;
    ir_interval_t          frame[$];
    bits       = {1'b1, device_bits, subdevice_bits, code};
    held_time  = '0;
    held_pulse = 1'b0;
    held_space = 1'b0;
    total      = '0;
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      // a one opens with a pulse, a zero with a space
      one         = bits[i];
      same_level  = one ? held_pulse : held_space;
      other_level = one ? held_space : held_pulse;
      if (same_level) begin
        // merge the held second half with this first half
        dur = {1'b0, held_time} + {1'b0, half_bit_us};
        frame.push_back(ir_interval_t'{dur, one, '0, 1'b0});
        total = total + TOTAL_W'(dur);
      end else begin
        if (other_level) begin
          dur = {1'b0, held_time};
          frame.push_back(ir_interval_t'{dur, ~one, '0, 1'b0});
          total = total + TOTAL_W'(dur);
        end
        dur = {1'b0, half_bit_us};
        frame.push_back(ir_interval_t'{dur, one, '0, 1'b0});
        total = total + TOTAL_W'(dur);
      end
      // hold back the second half: opposite level of the first
      held_time  = half_bit_us;
      held_pulse = ~one;
      held_space = one;
    end
    // flush the held half by its flag, even when its length is zero
    if (held_pulse || held_space) begin
      dur = {1'b0, held_time};
      frame.push_back(ir_interval_t'{dur, held_pulse, '0, 1'b0});
      total = total + TOTAL_W'(dur);
    end
    frame[frame.size() - 1].frame_total_us = total;
    frame[frame.size() - 1].last           = 1'b1;
    foreach (frame[k]) interval_q.push_back(frame[k]);
  endfunction

  // Print one line per mismatch (up to a cap) and count all of them.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH frame %0d: %s", $time, frames_done, what);
    end
  endtask

  // Write one register; called at a rising edge, returns at a rising edge.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_HALF_BIT_TIME:  half_bit_us    = value;
      REG_DEVICE_CODE:    device_bits    = value[CODE_W-1:0];
      REG_SUBDEVICE_CODE: subdevice_bits = value[CODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [HALF_BIT_W-1:0] half,
                              input logic [CODE_W-1:0] dev,
                              input logic [CODE_W-1:0] sub);
    write_register(REG_HALF_BIT_TIME, half);
    write_register(REG_DEVICE_CODE, CFG_DATA_W'(dev));
    write_register(REG_SUBDEVICE_CODE, CFG_DATA_W'(sub));
    settings_used++;
  endtask

  // Send one command beat. Valid stays high on return so that a following
  // beat with no gap keeps it up without a drop in the same step.
  task automatic send_command(input logic [CMD_BITS-1:0] code);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command_code <= code;
    do @(posedge clk); while (!cmd_ch.ready);
    encode_frame(code);
    frames_sent++;
  endtask

  // Drop valid, drain every owed interval, then let the back end settle.
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (interval_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Reset values: 315 us half bit, both codes zero, no writes yet.
  task automatic test_reset_defaults();
    send_command('0);
    send_command('1);
    send_command(CMD_BITS'(7'h55));
    send_command(CMD_BITS'(7'h2A));
    wait_idle();
  endtask

  // Extremes of the half bit time and of both address codes.
  task automatic test_code_extremes();
    load_setting(16'd1, 5'd31, 5'd0);
    send_command('1);
    send_command('0);
    wait_idle();
    load_setting(16'hFFFF, 5'd0, 5'd31);
    send_command(CMD_BITS'(7'h55));
    send_command(CMD_BITS'(7'h2A));
    wait_idle();
    load_setting(16'd1000, 5'd21, 5'd10);
    send_command('1);
    wait_idle();
  endtask

  // Zero half bit time: zero-length intervals still come out, flush included.
  task automatic test_zero_half_bit();
    load_setting(16'd0, 5'd31, 5'd31);
    send_command('0);
    send_command('1);
    send_command(CMD_BITS'(7'h55));
    wait_idle();
  endtask

  // Back-to-back frames, first with a free-running sink, then with a
  // stalling sink so the front-end queue fills and cmd must back off.
  task automatic test_back_to_back();
    load_setting(HALF_BIT_RESET, 5'd5, 5'd26);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (4) send_command(CMD_BITS'($urandom_range(0, 2**CMD_BITS - 1)));
    rx_steady = 1'b0;
    repeat (4) send_command(CMD_BITS'($urandom_range(0, 2**CMD_BITS - 1)));
    wait_idle();
    tx_steady = 1'b0;
  endtask

  // Random commands over several register settings, extremes included.
  task automatic test_random_settings();
    logic [HALF_BIT_W-1:0] half;
    logic [CMD_BITS-1:0]   code;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       half = 16'hFFFF;
        1:       half = 16'd1;
        2:       half = 16'd0;
        default: begin
          case ($urandom_range(0, 3))
            0:       half = 16'hFFFF;
            1:       half = HALF_BIT_W'($urandom_range(1, 400));
            default: half = HALF_BIT_W'($urandom_range(1, 65535));
          endcase
        end
      endcase
      // each side runs without idling in a quarter of the phases, drawn on its own
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      load_setting(half, CODE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 31)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          code = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          code = CMD_BITS'($urandom_range(0, 2**CMD_BITS - 1));
        end
        send_command(code);
      end
      wait_idle();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result side: draw a stall per beat, then compare each beat field by
  // field with the oldest owed interval.
  initial begin : result_checker
    ir_interval_t got;
    ir_interval_t want;
    int           stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got = ir_interval_t'{res_ch.duration_us, res_ch.is_pulse,
                           res_ch.frame_total_us, res_ch.last};
      intervals_done++;
      if (interval_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing owed: dur=%0d pulse=%0b total=%0d last=%0b",
                                  got.duration_us, got.is_pulse, got.frame_total_us, got.last));
      end else begin
        want = interval_q.pop_front();
        if (got.duration_us !== want.duration_us)
          report_mismatch($sformatf("duration_us %0d, want %0d",
                                    got.duration_us, want.duration_us));
        if (got.is_pulse !== want.is_pulse)
          report_mismatch($sformatf("is_pulse %0b, want %0b", got.is_pulse, want.is_pulse));
        if (got.frame_total_us !== want.frame_total_us)
          report_mismatch($sformatf("frame_total_us %0d, want %0d",
                                    got.frame_total_us, want.frame_total_us));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        if (want.last) frames_done++;
      end
    end
  end

  // Watchdog: far beyond the slowest correct run (about 3 ms).
  initial begin : watchdog
    #30_000_000;
    $display("Timeout with %0d intervals still owed", interval_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    // drive every input to a known value from time zero
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= '0;
    cfg_wr_data         <= '0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.command_code <= '0;
    half_bit_us    = HALF_BIT_RESET;
    device_bits    = '0;
    subdevice_bits = '0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    settings_used  = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_code_extremes();
    test_zero_half_bit();
    test_back_to_back();
    test_random_settings();
    wait_idle();

    $display("Sent %0d commands; covered %0d frames and %0d duration beats",
             frames_sent, frames_done, intervals_done);
    $display("over %0d register settings, half bit times from 0 to 65535 us,", settings_used);
    $display("with random stalls on both channels.");
    if (mismatch_count == 0 && interval_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d intervals never seen", mismatch_count, interval_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- biphase_ir_frame_encoder.f -----
rtl/bife_pkg.sv
rtl/bife_if.sv
rtl/bife_queue.sv
rtl/bife_front.sv
rtl/bife_back.sv
rtl/biphase_ir_frame_encoder.sv
rtl/bife_checker.sv
test/tb_biphase_ir_frame_encoder.sv
